/* rtl/nut_pkg.sv */
package nut_pkg;

  localparam int SITE_W  = 4;
  localparam int FUNC_W  = 2;
  localparam int MILES_W = 16;
  localparam int TOTAL_W = 32;
  localparam int MASK_W  = 16;

  // sites beyond this many cannot be addressed by a 4-bit site field
  localparam int SITE_ADDR_MAX = 16;
  localparam int NUM_SITES_DEF = 16;

  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_VISIT   = 2'd2;

endpackage

/* rtl/nut_dist_mem.sv */
module nut_dist_mem #(
  parameter int ADDR_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [nut_pkg::MILES_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [nut_pkg::MILES_W-1:0] rd_data
);
  import nut_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [MILES_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid_r;
  logic [MILES_W-1:0] rd_data_r;
  logic               rd_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_ok_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : '0;

endmodule

/* rtl/nearest_unvisited_tour_walker_core.sv */
// A request passes EXEC, then LOAD2 (a load) or VADD (a visit) if its sites are in range,
// then SCAN over the first min(NUM_SITES,16) sites and FIN, which raises the result strobe.
// A new request is taken only after the strobe, as busy drops in the strobe cycle; the
// row scan reads one table entry a cycle through the single read port of the memory.
// Result strobes for one cycle and cannot be stalled by the receiver.
// Synchronous reset: table reads as zero, only site 0 visited, total zero.
module nearest_unvisited_tour_walker_core #(
  parameter int NUM_SITES = nut_pkg::NUM_SITES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [nut_pkg::FUNC_W-1:0]   in_func,
  input  logic [nut_pkg::SITE_W-1:0]   in_site_a,
  input  logic [nut_pkg::SITE_W-1:0]   in_site_b,
  input  logic [nut_pkg::MILES_W-1:0]  in_miles,
  input  logic                         cfg_we,
  input  logic [nut_pkg::SITE_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  output logic [nut_pkg::SITE_W-1:0]   out_current_site,
  output logic [nut_pkg::TOTAL_W-1:0]  out_total_miles,
  output logic [nut_pkg::SITE_W-1:0]   out_closest_site,
  output logic                         out_closest_found,
  output logic [nut_pkg::MILES_W-1:0]  out_closest_miles,
  output logic [nut_pkg::MASK_W-1:0]   out_visited_mask
);
  import nut_pkg::*;

  localparam int ACTIVE = (NUM_SITES < SITE_ADDR_MAX) ? NUM_SITES : SITE_ADDR_MAX;
  localparam int IDX_W  = $clog2(ACTIVE);
  localparam int ADDR_W = 2 * IDX_W;
  localparam logic [SITE_W:0]  ACT_LIM  = (SITE_W+1)'(ACTIVE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ACTIVE - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_LOAD2, ST_VADD, ST_SCAN, ST_FIN
  } state_t;

  state_t              state_r;
  logic [FUNC_W-1:0]   func_r;
  logic [SITE_W-1:0]   site_a_r;
  logic [SITE_W-1:0]   site_b_r;
  logic [MILES_W-1:0]  miles_r;
  logic [SITE_W-1:0]   home_r;
  logic [SITE_W-1:0]   pos_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [MASK_W-1:0]   visited_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic                cmp_vld_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                found_r;
  logic [SITE_W-1:0]   best_site_r;
  logic [MILES_W-1:0]  best_d_r;

  logic                found_nxt;
  logic [SITE_W-1:0]   best_site_nxt;
  logic [MILES_W-1:0]  best_d_nxt;

  logic                a_ok;
  logic                b_ok;
  logic [SITE_W-1:0]   home_eff;
  logic [TOTAL_W:0]    sum_wide;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [MILES_W-1:0]  mem_rdata;
  logic                cand_ok;
  logic                take;

  assign a_ok     = {1'b0, site_a_r} < ACT_LIM;
  assign b_ok     = {1'b0, site_b_r} < ACT_LIM;
  assign home_eff = ({1'b0, home_r} < ACT_LIM) ? home_r : '0;
  assign sum_wide = {1'b0, total_r} + {{(TOTAL_W+1-MILES_W){1'b0}}, mem_rdata};
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {site_a_r[IDX_W-1:0], site_b_r[IDX_W-1:0]};
    mem_raddr = {pos_r[IDX_W-1:0], scan_idx_r};
    unique case (state_r)
      ST_EXEC: begin
        if (func_r == FUNC_LOAD) begin
          mem_we = a_ok && b_ok;
        end
        mem_raddr = {pos_r[IDX_W-1:0], site_a_r[IDX_W-1:0]};
      end
      ST_LOAD2: begin
        mem_we    = 1'b1;
        mem_waddr = {site_b_r[IDX_W-1:0], site_a_r[IDX_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  nut_dist_mem #(
    .ADDR_W (ADDR_W)
  ) u_dist_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (miles_r),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // compare stage: data for cmp_idx_r arrives in the cycle after its read
  always_comb begin
    cand_ok       = cmp_vld_r && !visited_r[cmp_idx_r] && (SITE_W'(cmp_idx_r) != pos_r);
    take          = cand_ok && (!found_r || (mem_rdata < best_d_r));
    found_nxt     = found_r;
    best_site_nxt = best_site_r;
    best_d_nxt    = best_d_r;
    if (take) begin
      found_nxt     = 1'b1;
      best_site_nxt = SITE_W'(cmp_idx_r);
      best_d_nxt    = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r <= '0;
    end else if (cfg_we) begin
      home_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pos_r      <= '0;
      total_r    <= '0;
      visited_r  <= MASK_W'(1);
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      cmp_vld_r <= 1'b0;
      found_r     <= found_nxt;
      best_site_r <= best_site_nxt;
      best_d_r    <= best_d_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            func_r   <= in_func;
            site_a_r <= in_site_a;
            site_b_r <= in_site_b;
            miles_r  <= in_miles;
            state_r  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          found_r     <= 1'b0;
          best_site_r <= '0;
          best_d_r    <= '0;
          scan_idx_r  <= '0;
          state_r     <= ST_SCAN;
          if (func_r == FUNC_LOAD && a_ok && b_ok) begin
            state_r <= ST_LOAD2;
          end else if (func_r == FUNC_RESTART) begin
            pos_r     <= home_eff;
            total_r   <= '0;
            visited_r <= MASK_W'(1) << home_eff;
          end else if (func_r == FUNC_VISIT && a_ok) begin
            state_r <= ST_VADD;
          end
        end
        ST_LOAD2: begin
          state_r <= ST_SCAN;
        end
        ST_VADD: begin
          total_r            <= sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
          pos_r              <= site_a_r;
          visited_r[site_a_r] <= 1'b1;
          state_r            <= ST_SCAN;
        end
        ST_SCAN: begin
          cmp_vld_r  <= 1'b1;
          cmp_idx_r  <= scan_idx_r;
          scan_idx_r <= scan_idx_r + 1'b1;
          if (scan_idx_r == LAST_IDX) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          out_valid         <= 1'b1;
          out_current_site  <= pos_r;
          out_total_miles   <= total_r;
          out_visited_mask  <= visited_r;
          out_closest_found <= found_nxt;
          out_closest_site  <= best_site_nxt;
          out_closest_miles <= best_d_nxt;
          state_r           <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_closest_found) |-> (out_closest_site == '0 && out_closest_miles == '0))
    else $error("empty result carries nonzero closest fields");

  a_closest_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_closest_found) |->
      (!out_visited_mask[out_closest_site] && out_closest_site != out_current_site))
    else $error("closest site is visited or current");

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_FIN) |-> !mem_we)
    else $error("table write during row scan");

endmodule
